// ===== rtl/integer_matrix_alu_assert.svh =====
// ----------------------------------------------------------------------------
// integer_matrix_alu assertion macros
// Concurrent assertion shorthands, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_ALU_ASSERT_SVH
`define INTEGER_MATRIX_ALU_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define IMA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer_matrix_alu: assertion failed");
// next-cycle implication
`define IMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer_matrix_alu: assertion failed");
`else
`define IMA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define IMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ima_pkg.sv =====
// ----------------------------------------------------------------------------
// ima_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ima_pkg;

  // matrix geometry and element width
  localparam int MaxDim    = 8;
  localparam int ElemWidth = 32;
  localparam int IdxW      = $clog2(MaxDim);
  localparam int AddrW     = 2 * IdxW;
  localparam int Depth     = 2 ** AddrW;
  localparam int DimW      = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 4;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } ima_act_e;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_INC = 3'd3,
    OP_DEC = 3'd4,
    OP_EQ  = 3'd5,
    OP_NE  = 3'd6,
    OP_RSV = 3'd7
  } ima_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_ROWS = 3'd0,
    CFG_A_COLS = 3'd1,
    CFG_B_ROWS = 3'd2,
    CFG_B_COLS = 3'd3,
    CFG_OP     = 3'd4
  } ima_cfg_e;

  typedef enum logic [1:0] {
    KIND_ELEM = 2'd0,
    KIND_FLAG = 2'd1,
    KIND_ERR  = 2'd2
  } ima_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_ACCUM,
    ST_EMIT,
    ST_FLAG,
    ST_ERROR
  } ima_state_e;

  // controller to datapath
  typedef struct packed {
    logic      wr_a;
    logic      wr_b;
    logic      start;
    logic      exec;
    logic      accum;
    logic      k_inc;
    logic      adv;
    logic      out_load;
    ima_kind_e kind;
  } ima_cmd_t;

  // datapath to controller
  typedef struct packed {
    ima_op_e op;
    logic    dim_err;
    logic    shape_same;
    logic    k_last;
    logic    ij_last;
    logic    out_free;
  } ima_sts_t;

  function automatic logic dim_ok(input logic [DimW-1:0] d);
    return (d != '0) && (d <= DimW'(MaxDim));
  endfunction

endpackage

// ===== rtl/ima_ram.sv =====
// ----------------------------------------------------------------------------
// ima_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ima_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ima_ctrl.sv =====
// ----------------------------------------------------------------------------
// ima_ctrl
// Sequencer: input handshake, compute walk over elements, result emission.
// ----------------------------------------------------------------------------
`include "integer_matrix_alu_assert.svh"

module ima_ctrl import ima_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  ima_sts_t   sts_i,
  output ima_cmd_t   cmd_o
);

  ima_state_e state_q, state_d;
  logic       is_cmp;
  logic       is_mul;

  assign is_cmp = (sts_i.op == OP_EQ) || (sts_i.op == OP_NE);
  assign is_mul = (sts_i.op == OP_MUL);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = KIND_ELEM;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (ima_act_e'(action_i))
            ACT_LOAD_A: cmd_o.wr_a = 1'b1;
            ACT_LOAD_B: cmd_o.wr_b = 1'b1;
            ACT_COMPUTE: begin
              cmd_o.start = 1'b1;
              priority if (sts_i.op == OP_RSV) begin
                state_d = ST_IDLE;
              end else if (sts_i.dim_err) begin
                state_d = ST_ERROR;
              end else if (is_cmp && !sts_i.shape_same) begin
                state_d = ST_FLAG;
              end else begin
                state_d = ST_READ;
              end
            end
            ACT_NONE: ;
            default: ;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (is_cmp) begin
          if (sts_i.ij_last) begin
            state_d = ST_FLAG;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = ST_READ;
          end
        end else begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (is_mul && !sts_i.k_last) begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_READ;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.ij_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = ST_READ;
          end
        end
      end
      ST_FLAG: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = KIND_FLAG;
          state_d        = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.kind     = KIND_ERR;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reserved operation code yields no work
  `IMA_ASSERT_NEXT(a_rsv_idle, clk_i, rst_ni, cmd_o.start && sts_i.op == OP_RSV, state_q == ST_IDLE)
  // a result is only loaded into a free output register
  `IMA_ASSERT_IMPLY(a_load_free, clk_i, rst_ni, cmd_o.out_load, sts_i.out_free)
  // element emission either finishes or starts the next element read
  `IMA_ASSERT_NEXT(a_emit_next, clk_i, rst_ni, state_q == ST_EMIT && sts_i.out_free, state_q == ST_IDLE || state_q == ST_READ)

endmodule

// ===== rtl/ima_dp.sv =====
// ----------------------------------------------------------------------------
// ima_dp
// Datapath: config registers, matrix stores, counters, ALU, output register.
// ----------------------------------------------------------------------------
module ima_dp import ima_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic [IdxW-1:0]             row_index_i,
  input  logic [IdxW-1:0]             col_index_i,
  input  logic signed [ElemWidth-1:0] element_i,
  input  ima_cmd_t                    cmd_i,
  output ima_sts_t                    sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IdxW-1:0]             out_row_o,
  output logic [IdxW-1:0]             out_col_o,
  output logic signed [ElemWidth-1:0] out_value_o,
  output logic                        last_o,
  output logic                        compare_flag_o,
  output logic                        status_o
);

  logic [DimW-1:0]      a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  ima_op_e              op_q;
  logic [IdxW-1:0]      i_q, j_q, k_q;
  logic [ElemWidth-1:0] stage_q, acc_q;
  logic                 same_q;
  logic                 out_valid_q;
  logic [IdxW-1:0]      out_row_q, out_col_q;
  logic [ElemWidth-1:0] out_value_q;
  logic                 last_q, flag_q, status_q;

  logic [AddrW-1:0]     a_raddr, b_raddr, waddr;
  logic [ElemWidth-1:0] a_rdata, b_rdata, alu_res;
  logic [DimW-1:0]      cols;
  logic                 is_mul, j_last, i_last, out_free;

  assign is_mul = (op_q == OP_MUL);
  assign cols   = is_mul ? b_cols_q : a_cols_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DimW'(3);
      a_cols_q <= DimW'(3);
      b_rows_q <= DimW'(3);
      b_cols_q <= DimW'(3);
      op_q     <= OP_ADD;
    end else if (cfg_we_i) begin
      unique case (ima_cfg_e'(cfg_index_i))
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        CFG_OP:     op_q     <= ima_op_e'(cfg_data_i[2:0]);
        default: ;
      endcase
    end
  end

  // shape checks
  always_comb begin
    sts_o.op         = op_q;
    sts_o.shape_same = dim_ok(a_rows_q) && dim_ok(a_cols_q) &&
                       (a_rows_q == b_rows_q) && (a_cols_q == b_cols_q);
    unique case (op_q)
      OP_ADD, OP_SUB: sts_o.dim_err = !sts_o.shape_same;
      OP_MUL: sts_o.dim_err = !dim_ok(a_rows_q) || !dim_ok(a_cols_q) ||
                              !dim_ok(b_cols_q) || (a_cols_q != b_rows_q);
      OP_INC, OP_DEC: sts_o.dim_err = !dim_ok(a_rows_q) || !dim_ok(a_cols_q);
      default: sts_o.dim_err = 1'b0;
    endcase
  end

  // loop position
  assign j_last         = (DimW'(j_q) == cols - DimW'(1));
  assign i_last         = (DimW'(i_q) == a_rows_q - DimW'(1));
  assign sts_o.ij_last  = i_last && j_last;
  assign sts_o.k_last   = (DimW'(k_q) == a_cols_q - DimW'(1));
  assign sts_o.out_free = out_free;

  // matrix stores, row-major addressing
  assign waddr   = {row_index_i, col_index_i};
  assign a_raddr = {i_q, (is_mul ? k_q : j_q)};
  assign b_raddr = {(is_mul ? k_q : i_q), j_q};

  ima_ram #(
    .Width (ElemWidth),
    .Depth (Depth)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  ima_ram #(
    .Width (ElemWidth),
    .Depth (Depth)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // element operation, wraps at element width
  always_comb begin
    unique case (op_q)
      OP_ADD:  alu_res = a_rdata + b_rdata;
      OP_SUB:  alu_res = a_rdata - b_rdata;
      OP_MUL:  alu_res = a_rdata * b_rdata;
      OP_INC:  alu_res = a_rdata + ElemWidth'(1);
      OP_DEC:  alu_res = a_rdata - ElemWidth'(1);
      default: alu_res = '0;
    endcase
  end

  // counters and compare flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      j_q    <= '0;
      k_q    <= '0;
      same_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        i_q    <= '0;
        j_q    <= '0;
        k_q    <= '0;
        same_q <= sts_o.shape_same;
      end else begin
        if (cmd_i.exec && (a_rdata != b_rdata)) begin
          same_q <= 1'b0;
        end
        if (cmd_i.k_inc) begin
          k_q <= k_q + IdxW'(1);
        end
        if (cmd_i.adv) begin
          k_q <= '0;
          if (j_last) begin
            j_q <= '0;
            i_q <= i_q + IdxW'(1);
          end else begin
            j_q <= j_q + IdxW'(1);
          end
        end
      end
    end
  end

  // product/result stage and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      stage_q <= alu_res;
    end
    if (cmd_i.start || cmd_i.adv) begin
      acc_q <= '0;
    end else if (cmd_i.accum) begin
      acc_q <= is_mul ? (acc_q + stage_q) : stage_q;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.kind)
        KIND_ELEM: begin
          out_row_q   <= i_q;
          out_col_q   <= j_q;
          out_value_q <= acc_q;
          last_q      <= sts_o.ij_last;
          flag_q      <= 1'b0;
          status_q    <= 1'b0;
        end
        KIND_FLAG: begin
          out_row_q   <= '0;
          out_col_q   <= '0;
          out_value_q <= '0;
          last_q      <= 1'b1;
          flag_q      <= (op_q == OP_EQ) ? same_q : !same_q;
          status_q    <= 1'b0;
        end
        default: begin
          out_row_q   <= '0;
          out_col_q   <= '0;
          out_value_q <= '0;
          last_q      <= 1'b1;
          flag_q      <= 1'b0;
          status_q    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_value_o    = out_value_q;
  assign last_o         = last_q;
  assign compare_flag_o = flag_q;
  assign status_o       = status_q;

endmodule

// ===== rtl/integer_matrix_alu.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_alu
// Integer matrix unit: loads A and B, then adds, subtracts, multiplies,
// increments, decrements or compares them on a compute beat.
// ----------------------------------------------------------------------------
// Usage:
//  - Config: write a_rows, a_cols, b_rows, b_cols (index 0..3) and operation
//    (index 4) on the cfg channel while idle; cfg_ready_o is always high.
//  - Input beats: action 0/1 stores element into A/B at row/col and gives
//    no result; a new load is taken every cycle while idle.
//  - A compute beat stalls the input until its last result is in the output
//    register. Results leave in row-major order with last_o on the final one;
//    compares and dimension errors give one result.
//  - Per element, add/sub/inc/dec walk read, execute, accumulate, emit;
//    multiply repeats read, execute, accumulate per a_cols term, then emits;
//    compare walks read and execute, then flags. This follows from the single
//    read port of each matrix store and the shared multiply/accumulate stage.
//  - The output register holds its beat while out_stall_i is high; the walk
//    waits on it, and the input stays stalled until the walk is done.
//  - Reset clears config to 3x3 add and empties the output; matrix stores
//    are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module integer_matrix_alu import ima_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [IdxW-1:0]             row_index_i,
  input  logic [IdxW-1:0]             col_index_i,
  input  logic signed [ElemWidth-1:0] element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [IdxW-1:0]             out_row_o,
  output logic [IdxW-1:0]             out_col_o,
  output logic signed [ElemWidth-1:0] out_value_o,
  output logic                        last_o,
  output logic                        compare_flag_o,
  output logic                        status_o
);

  ima_cmd_t cmd;
  ima_sts_t sts;

  // config writes never wait
  assign cfg_ready_o = 1'b1;

  ima_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ima_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_i      (element_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .out_value_o    (out_value_o),
    .last_o         (last_o),
    .compare_flag_o (compare_flag_o),
    .status_o       (status_o)
  );

endmodule

// ===== bench/integer_matrix_alu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_matrix_alu_checker
// Watches the register, input and result channels of the matrix unit. Keeps
// its own copy of both matrix stores and the dimension/operation registers,
// works out the result beats of every compute and checks them in order.
// ----------------------------------------------------------------------------
module integer_matrix_alu_checker import ima_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  action_i,
  input  logic [IdxW-1:0]             row_index_i,
  input  logic [IdxW-1:0]             col_index_i,
  input  logic signed [ElemWidth-1:0] element_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [IdxW-1:0]             out_row_i,
  input  logic [IdxW-1:0]             out_col_i,
  input  logic signed [ElemWidth-1:0] out_value_i,
  input  logic                        last_i,
  input  logic                        compare_flag_i,
  input  logic                        status_i,
  output int                          errors_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [IdxW-1:0]      row;
    logic [IdxW-1:0]      col;
    logic [ElemWidth-1:0] value;
    logic                 last;
    logic                 flag;
    logic                 status;
  } mat_result_t;

  logic [ElemWidth-1:0] store_a [Depth];
  logic [ElemWidth-1:0] store_b [Depth];
  logic [DimW-1:0]      a_rows, a_cols, b_rows, b_cols;
  ima_op_e              op_sel;
  mat_result_t          result_fifo [$];
  int                   mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit dim_legal(input logic [DimW-1:0] d);
    return (d >= 1) && (d <= MaxDim);
  endfunction

  task automatic push_result(input int r, input int c, input logic [ElemWidth-1:0] v,
                             input bit lst, input bit flg, input bit sts);
    mat_result_t res;
    res.row    = IdxW'(r);
    res.col    = IdxW'(c);
    res.value  = v;
    res.last   = lst;
    res.flag   = flg;
    res.status = sts;
    result_fifo.push_back(res);
  endtask

  // result beats of one compute under the current registers
  task automatic compute_matrix_op();
    bit                   same;
    logic [ElemWidth-1:0] acc, x, y, v;
    case (op_sel)
      OP_EQ, OP_NE: begin
        same = dim_legal(a_rows) && dim_legal(a_cols) &&
               a_rows == b_rows && a_cols == b_cols;
        if (same)
          for (int i = 0; i < a_rows; i++)
            for (int j = 0; j < a_cols; j++)
              if (store_a[i*MaxDim+j] !== store_b[i*MaxDim+j]) same = 1'b0;
        push_result(0, 0, '0, 1'b1, (op_sel == OP_EQ) ? same : !same, 1'b0);
      end
      OP_MUL: begin
        if (!dim_legal(a_rows) || !dim_legal(a_cols) || !dim_legal(b_cols) ||
            a_cols != b_rows) begin
          push_result(0, 0, '0, 1'b1, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < a_rows; i++)
            for (int j = 0; j < b_cols; j++) begin
              acc = '0;
              for (int k = 0; k < a_cols; k++)
                acc += store_a[i*MaxDim+k] * store_b[k*MaxDim+j];
              push_result(i, j, acc, (i == a_rows - 1) && (j == b_cols - 1), 1'b0, 1'b0);
            end
        end
      end
      OP_RSV: ;
      default: begin
        if (!dim_legal(a_rows) || !dim_legal(a_cols) ||
            ((op_sel == OP_ADD || op_sel == OP_SUB) &&
             (a_rows != b_rows || a_cols != b_cols))) begin
          push_result(0, 0, '0, 1'b1, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < a_rows; i++)
            for (int j = 0; j < a_cols; j++) begin
              x = store_a[i*MaxDim+j];
              y = store_b[i*MaxDim+j];
              case (op_sel)
                OP_ADD:  v = x + y;
                OP_SUB:  v = x - y;
                OP_INC:  v = x + 1'b1;
                default: v = x - 1'b1;
              endcase
              push_result(i, j, v, (i == a_rows - 1) && (j == a_cols - 1), 1'b0, 1'b0);
            end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : beat_monitor
    mat_result_t want;
    if (!rst_ni) begin
      a_rows = DimW'(3);
      a_cols = DimW'(3);
      b_rows = DimW'(3);
      b_cols = DimW'(3);
      op_sel = OP_ADD;
      result_fifo.delete();
      pending_o <= 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected, value %0h",
                                    out_value_i));
        end else begin
          want = result_fifo.pop_front();
          if (out_row_i !== want.row)
            report_mismatch($sformatf("out_row got %0d expected %0d", out_row_i, want.row));
          if (out_col_i !== want.col)
            report_mismatch($sformatf("out_col got %0d expected %0d", out_col_i, want.col));
          if (out_value_i !== want.value)
            report_mismatch($sformatf("out_value got %0h expected %0h",
                                      out_value_i, want.value));
          if (last_i !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b", last_i, want.last));
          if (compare_flag_i !== want.flag)
            report_mismatch($sformatf("compare_flag got %0b expected %0b",
                                      compare_flag_i, want.flag));
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b", status_i, want.status));
        end
      end
      // register write beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_A_ROWS: a_rows = cfg_data_i;
          CFG_A_COLS: a_cols = cfg_data_i;
          CFG_B_ROWS: b_rows = cfg_data_i;
          CFG_B_COLS: b_cols = cfg_data_i;
          CFG_OP:     op_sel = ima_op_e'(cfg_data_i[2:0]);
          default: ;
        endcase
      end
      // input beat: element load or compute
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ACT_LOAD_A:  store_a[{row_index_i, col_index_i}] = element_i;
          ACT_LOAD_B:  store_b[{row_index_i, col_index_i}] = element_i;
          ACT_COMPUTE: compute_matrix_op();
          default: ;
        endcase
      end
      pending_o <= result_fifo.size();
    end
  end

endmodule

// ===== bench/tb_integer_matrix_alu.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_matrix_alu
// Drives the matrix unit with a short directed pass over extreme elements,
// every operation and the error, mismatch and ignored cases, then random
// load/compute sequences under random dimensions with random idle cycles on
// both channels. A separate checker predicts and compares the result beats.
// ----------------------------------------------------------------------------
module tb_integer_matrix_alu;
  import ima_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int SettleCycles = 20;
  localparam int RandomItems  = 350;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CfgIdxW-1:0]          cfg_index;
  logic [CfgDataW-1:0]         cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  action;
  logic [IdxW-1:0]             row_index;
  logic [IdxW-1:0]             col_index;
  logic signed [ElemWidth-1:0] element;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [IdxW-1:0]             out_row;
  logic [IdxW-1:0]             out_col;
  logic signed [ElemWidth-1:0] out_value;
  logic                        last;
  logic                        compare_flag;
  logic                        status;

  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   beat_count  = 0;
  bit   quiet       = 1'b0;

  // which entries hold a loaded value, and what A holds
  bit                   a_loaded [Depth];
  bit                   b_loaded [Depth];
  logic [ElemWidth-1:0] a_shadow [Depth];
  ima_op_e              op_sel;

  integer_matrix_alu uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .row_index_i    (row_index),
    .col_index_i    (col_index),
    .element_i      (element),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .out_value_o    (out_value),
    .last_o         (last),
    .compare_flag_o (compare_flag),
    .status_o       (status)
  );

  integer_matrix_alu_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .row_index_i    (row_index),
    .col_index_i    (col_index),
    .element_i      (element),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_row_i      (out_row),
    .out_col_i      (out_col),
    .out_value_i    (out_value),
    .last_i         (last),
    .compare_flag_i (compare_flag),
    .status_i       (status),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side stalls at random outside the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 7);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ElemWidth-1:0] pick_extreme(input int k);
    case (k % 6)
      0:       return {1'b0, {(ElemWidth-1){1'b1}}};
      1:       return {1'b1, {(ElemWidth-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      4:       return ElemWidth'(1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ElemWidth-1:0] rand_elem();
    return ($urandom_range(0, 7) < 5) ? $urandom() : pick_extreme($urandom_range(0, 4));
  endfunction

  function automatic bit dim_usable(input logic [DimW-1:0] d);
    return (d >= 1) && (d <= MaxDim);
  endfunction

  // zero, small, or above the store size
  function automatic logic [DimW-1:0] wild_dim();
    case ($urandom_range(0, 7))
      0:       return '0;
      6, 7:    return DimW'($urandom_range(MaxDim + 1, 2**DimW - 1));
      default: return DimW'($urandom_range(1, 3));
    endcase
  endfunction

  // one input beat, with random idle cycles ahead of it outside the quiet stretch
  task automatic send_beat(input ima_act_e act, input int r, input int c,
                           input logic [ElemWidth-1:0] e);
    logic [AddrW-1:0] addr;
    addr = {IdxW'(r), IdxW'(c)};
    if (!quiet)
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid  <= 1'b1;
    action    <= act;
    row_index <= IdxW'(r);
    col_index <= IdxW'(c);
    element   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_LOAD_A) begin
      a_loaded[addr] = 1'b1;
      a_shadow[addr] = e;
    end
    if (act == ACT_LOAD_B) b_loaded[addr] = 1'b1;
    if (act == ACT_LOAD_A || act == ACT_LOAD_B || (act == ACT_COMPUTE && op_sel != OP_RSV))
      beat_count++;
  endtask

  // wait for the unit to drain, with margin for a compute that gives no beat
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DimW-1:0] ar, input logic [DimW-1:0] ac,
                            input logic [DimW-1:0] br, input logic [DimW-1:0] bc,
                            input logic [CfgDataW-1:0] op_word);
    settle();
    cfg_beat(CFG_A_ROWS, ar);
    cfg_beat(CFG_A_COLS, ac);
    cfg_beat(CFG_B_ROWS, br);
    cfg_beat(CFG_B_COLS, bc);
    // now and then a write to an index past the register file
    if ($urandom_range(0, 9) == 0)
      cfg_beat(CfgIdxW'(CFG_OP + 1 + $urandom_range(0, 2)), CfgDataW'($urandom()));
    cfg_beat(CFG_OP, op_word);
    cfg_valid <= 1'b0;
    op_sel = ima_op_e'(op_word[2:0]);
  endtask

  // load every empty entry of a region, more when fresh, stray beats mixed in
  task automatic refresh_region(input bit to_b, input int rows, input int cols,
                                input bit fresh);
    ima_act_e         act;
    logic [AddrW-1:0] addr;
    bit               have;
    act = to_b ? ACT_LOAD_B : ACT_LOAD_A;
    for (int i = 0; i < rows; i++)
      for (int j = 0; j < cols; j++) begin
        addr = {IdxW'(i), IdxW'(j)};
        have = to_b ? b_loaded[addr] : a_loaded[addr];
        if ($urandom_range(0, 9) == 0)
          send_beat(($urandom_range(0, 2) == 0) ? ACT_NONE : ima_act_e'($urandom_range(0, 1)),
                    $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
        if (!have || (fresh && $urandom_range(0, 3) != 0))
          send_beat(act, i, j, rand_elem());
      end
  endtask

  // new registers, loads for the region they use, then one or two computes
  task automatic run_scenario(input bit big);
    logic [DimW-1:0] ar, ac, br, bc;
    logic [2:0]      opc;
    int              m, n, p, sel;
    sel = $urandom_range(0, 20);
    opc = (sel == 0) ? OP_RSV : 3'(sel % 7);
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 3);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 3);
    p = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxDim) : $urandom_range(1, 3);
    if (big) begin
      opc = OP_MUL;
      m = MaxDim;
      n = MaxDim;
      p = MaxDim;
    end
    if (!big && $urandom_range(0, 99) < 15) begin
      ar = wild_dim();
      ac = wild_dim();
      br = wild_dim();
      bc = wild_dim();
    end else if (opc == OP_MUL) begin
      ar = DimW'(m);
      ac = DimW'(n);
      br = DimW'(n);
      bc = DimW'(p);
    end else begin
      ar = DimW'(m);
      ac = DimW'(n);
      br = DimW'(m);
      bc = DimW'(n);
    end
    write_regs(ar, ac, br, bc, {1'($urandom_range(0, 1)), opc});
    if (dim_usable(ar) && dim_usable(ac)) begin
      refresh_region(1'b0, int'(ar), int'(ac), 1'b1);
      refresh_region(1'b1, int'(ar), int'(ac), 1'b0);
    end
    if (dim_usable(br) && dim_usable(bc)) refresh_region(1'b1, int'(br), int'(bc), 1'b1);
    // copy A into B now and then so that the compare can come out equal
    if ((op_sel == OP_EQ || op_sel == OP_NE) && dim_usable(ar) && dim_usable(ac) &&
        $urandom_range(0, 1) == 1) begin
      for (int i = 0; i < ar; i++)
        for (int j = 0; j < ac; j++)
          send_beat(ACT_LOAD_B, i, j, a_shadow[{IdxW'(i), IdxW'(j)}]);
      if ($urandom_range(0, 2) == 0)
        send_beat(ACT_LOAD_B, $urandom_range(0, ar - 1), $urandom_range(0, ac - 1),
                  rand_elem());
    end
    repeat ($urandom_range(1, 2))
      send_beat(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_LOAD_A;
    row_index = '0;
    col_index = '0;
    element   = '0;
    op_sel    = OP_ADD;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // directed: extreme elements in 2x2 A and B, then each operation
    write_regs(DimW'(2), DimW'(2), DimW'(2), DimW'(2), CfgDataW'(OP_ADD));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        send_beat(ACT_LOAD_A, i, j, pick_extreme(i * 2 + j));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        send_beat(ACT_LOAD_B, i, j, pick_extreme(4 + i * 2 + j));
    send_beat(ACT_COMPUTE, 7, 7, '1);
    for (int k = OP_SUB; k <= OP_NE; k++) begin
      write_regs(DimW'(2), DimW'(2), DimW'(2), DimW'(2), CfgDataW'(k));
      send_beat(ACT_COMPUTE, 0, 0, '0);
    end
    // reserved operation and unused action give nothing
    write_regs(DimW'(2), DimW'(2), DimW'(2), DimW'(2), CfgDataW'(OP_RSV));
    send_beat(ACT_COMPUTE, 3, 4, rand_elem());
    send_beat(ACT_NONE, 7, 0, rand_elem());
    // shape mismatch on add and multiply, shapes differ on equal
    write_regs(DimW'(2), DimW'(2), DimW'(1), DimW'(2), CfgDataW'(OP_ADD));
    send_beat(ACT_COMPUTE, 0, 0, '0);
    write_regs(DimW'(2), DimW'(2), DimW'(1), DimW'(2), CfgDataW'(OP_MUL));
    send_beat(ACT_COMPUTE, 0, 0, '0);
    write_regs(DimW'(2), DimW'(2), DimW'(1), DimW'(2), CfgDataW'(OP_EQ));
    send_beat(ACT_COMPUTE, 0, 0, '0);
    // zero and out-of-range dimensions
    write_regs(DimW'(0), DimW'(2), DimW'(2), DimW'(2), CfgDataW'(OP_INC));
    send_beat(ACT_COMPUTE, 0, 0, '0);
    write_regs(DimW'(2), DimW'(15), DimW'(2), DimW'(15), CfgDataW'(OP_SUB));
    send_beat(ACT_COMPUTE, 0, 0, '0);
    write_regs(DimW'(1), DimW'(1), DimW'(1), DimW'(1), {1'b1, OP_MUL});
    send_beat(ACT_COMPUTE, 0, 0, '0);

    // random: one full-size multiply, then mostly small sequences
    beat_count = 0;
    run_scenario(1'b1);
    while (beat_count < RandomItems) begin
      quiet = (beat_count > 150) && (beat_count < 230);
      run_scenario(1'b0);
    end
    quiet = 1'b0;

    settle();
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
